>>> src/fmb_pkg.sv
// fmb_pkg: shared types, constants and scoring functions for the fuzzy match block
// no dependencies; imported by fmb_front, fmb_queue, fmb_back and the top level
`timescale 1ns / 1ps

package fmb_pkg;

    localparam int MAX_PATTERN = 16;
    localparam int PAT_BITS    = 8 * MAX_PATTERN;
    localparam int SCORE_W     = 13;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [7:0] FOLD_MASK = 8'hDF;
    localparam logic [7:0] SEP_MAX   = 8'd32;
    localparam logic [4:0] LEN_MAX   = 5'(MAX_PATTERN);

    localparam logic signed [SCORE_W:0] HIT_BONUS    = 14'sd10;
    localparam logic signed [SCORE_W:0] CONSEC_BONUS = 14'sd5;
    localparam logic signed [SCORE_W:0] MISS_COST    = 14'sd1;
    localparam logic signed [SCORE_W:0] SCORE_HI     = 14'sd4095;
    localparam logic signed [SCORE_W:0] SCORE_LO     = -14'sd4096;
    localparam logic [3:0]              LEAD_STEP    = 4'd3;
    localparam logic [3:0]              LEAD_CAP     = 4'd9;

    typedef enum logic [1:0] {
        REG_PATTERN_LO  = 2'd0,
        REG_PATTERN_HI  = 2'd1,
        REG_PATTERN_LEN = 2'd2
    } reg_idx_t;

    // one character to score, with its neighbor tests already done
    typedef struct packed {
        logic       valid;
        logic [7:0] c;
        logic       lead;
        logic       sep;
    } score_op_t;

    // one queue entry: up to two characters and the end-of-candidate marks
    typedef struct packed {
        score_op_t op_a;
        score_op_t op_b;
        logic      end_item;
        logic      end_list;
        logic      nonempty;
    } work_t;

    typedef struct packed {
        logic [4:0]                 pos;
        logic                       consec;
        logic signed [SCORE_W-1:0]  run;
        logic [3:0]                 pen;
    } cand_t;

    function automatic logic signed [SCORE_W-1:0] sat13(input logic signed [SCORE_W:0] v);
        logic signed [SCORE_W-1:0] r;
        if (v > SCORE_HI)
            r = SCORE_HI[SCORE_W-1:0];
        else if (v < SCORE_LO)
            r = SCORE_LO[SCORE_W-1:0];
        else
            r = v[SCORE_W-1:0];
        return r;
    endfunction

    function automatic logic is_sep(input logic [7:0] c);
        return c <= SEP_MAX;
    endfunction

    function automatic cand_t score_step(
        input cand_t                s,
        input score_op_t            op,
        input logic [PAT_BITS-1:0]  pat,
        input logic [4:0]           len
    );
        cand_t                    r;
        logic [7:0]               pb;
        logic                     hit;
        logic signed [SCORE_W:0]  x;
        logic signed [SCORE_W:0]  run_ext;
        logic [4:0]               pen_sum;
        r       = s;
        pb      = pat[{s.pos[3:0], 3'b000} +: 8];
        hit     = ((op.c ^ pb) & FOLD_MASK) == 8'd0;
        run_ext = $signed({s.run[SCORE_W-1], s.run});
        x       = '0;
        pen_sum = {1'b0, s.pen} + {1'b0, LEAD_STEP};
        if (op.valid && (s.pos < len))
        begin
            if (hit)
            begin
                if (op.sep || op.lead)
                    x = HIT_BONUS;
                else if (s.consec)
                    x = CONSEC_BONUS;
                r.consec = 1'b1;
                r.run    = sat13(run_ext + x);
                r.pos    = s.pos + 5'd1;
            end
            else
            begin
                r.consec = 1'b0;
                r.run    = sat13(run_ext - MISS_COST);
                if (op.lead)
                    r.pen = (pen_sum > {1'b0, LEAD_CAP}) ? LEAD_CAP : pen_sum[3:0];
            end
        end
        return r;
    endfunction

endpackage

>>> src/fmb_front.sv
// fmb_front: takes input beats, holds each character back by one and
// builds queue entries with the leading and separator tests; uses fmb_pkg
`timescale 1ns / 1ps

module fmb_front
    import fmb_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] ch,
    input  logic       has_char,
    input  logic       end_of_item,
    input  logic       end_of_list,
    input  logic       q_ready,
    output logic       q_push,
    output work_t      q_data
);

    logic [7:0] held_reg,     held_next;
    logic       held_vld_reg, held_vld_next;
    logic       prev_sep_reg, prev_sep_next;
    logic       nonempty_reg, nonempty_next;
    logic       accept;
    logic       a_valid;
    logic       sep_after_a;

    assign in_ready = q_ready;
    assign accept   = in_valid && in_ready;
    assign a_valid  = has_char && held_vld_reg;
    // separator test for whatever follows the held character once it is scored
    assign sep_after_a = a_valid ? is_sep(held_reg) : prev_sep_reg;

    always_comb
    begin
        q_data.op_a.valid = a_valid;
        q_data.op_a.c     = held_reg;
        q_data.op_a.lead  = held_reg[6] && !ch[6];
        q_data.op_a.sep   = prev_sep_reg;
        if (has_char)
        begin
            q_data.op_b.valid = end_of_item;
            q_data.op_b.c     = ch;
            q_data.op_b.lead  = ch[6];
            q_data.op_b.sep   = sep_after_a;
        end
        else
        begin
            q_data.op_b.valid = end_of_item && held_vld_reg;
            q_data.op_b.c     = held_reg;
            q_data.op_b.lead  = held_reg[6];
            q_data.op_b.sep   = prev_sep_reg;
        end
        q_data.end_item = end_of_item;
        q_data.end_list = end_of_item && end_of_list;
        q_data.nonempty = nonempty_reg || has_char;
        q_push = accept && (end_of_item || a_valid);
    end

    always_comb
    begin
        held_next     = held_reg;
        held_vld_next = held_vld_reg;
        prev_sep_next = prev_sep_reg;
        nonempty_next = nonempty_reg;
        if (accept)
        begin
            if (end_of_item)
            begin
                held_vld_next = 1'b0;
                prev_sep_next = 1'b1;
                nonempty_next = 1'b0;
            end
            else if (has_char)
            begin
                held_next     = ch;
                held_vld_next = 1'b1;
                prev_sep_next = sep_after_a;
                nonempty_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_vld_reg <= 1'b0;
            prev_sep_reg <= 1'b1;
            nonempty_reg <= 1'b0;
        end
        else
        begin
            held_vld_reg <= held_vld_next;
            prev_sep_reg <= prev_sep_next;
            nonempty_reg <= nonempty_next;
        end
    end

    always_ff @(posedge clk)
    begin
        held_reg <= held_next;
    end

endmodule

>>> src/fmb_queue.sv
// fmb_queue: short fifo of work entries between the front and back parts
// uses fmb_pkg for the entry type and depth
`timescale 1ns / 1ps

module fmb_queue
    import fmb_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  work_t push_data,
    output logic  not_full,
    input  logic  pop,
    output logic  not_empty,
    output work_t pop_data
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    work_t              slots_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg,  count_next;
    logic               do_push;
    logic               do_pop;

    assign not_full  = count_reg != CNT_W'(QUEUE_DEPTH);
    assign not_empty = count_reg != '0;
    assign do_push   = push && not_full;
    assign do_pop    = pop && not_empty;
    assign pop_data  = slots_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        count_next = count_reg + CNT_W'(do_push) - CNT_W'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slots_reg[wr_ptr_reg] <= push_data;
    end

endmodule

>>> src/fmb_back.sv
// fmb_back: scores queued characters against the pattern, closes candidates,
// tracks the best match and holds the result register; uses fmb_pkg
`timescale 1ns / 1ps

module fmb_back
    import fmb_pkg::*;
#(
    parameter int MAX_ITEMS = 1024
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [PAT_BITS-1:0]        pattern,
    input  logic [4:0]                 pattern_len,
    input  logic                       q_valid,
    input  work_t                      q_data,
    output logic                       q_pop,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [9:0]                 item_index,
    output logic                       matched,
    output logic signed [SCORE_W-1:0]  item_score,
    output logic signed [10:0]         best_index,
    output logic signed [SCORE_W-1:0]  best_score,
    output logic                       list_done
);

    localparam int CNT_W = $clog2(MAX_ITEMS);

    cand_t                      cand_reg, cand_next;
    logic [CNT_W-1:0]           cnt_reg, cnt_next;
    logic                       best_vld_reg, best_vld_next;
    logic [CNT_W-1:0]           best_cnt_reg, best_cnt_next;
    logic signed [SCORE_W-1:0]  best_val_reg, best_val_next;

    logic                       out_vld_reg;
    logic [9:0]                 idx_reg;
    logic                       match_reg;
    logic signed [SCORE_W-1:0]  score_reg;
    logic signed [10:0]         bidx_reg;
    logic signed [SCORE_W-1:0]  bval_reg;
    logic                       done_reg;

    logic [4:0]                 eff_len;
    cand_t                      after_a;
    cand_t                      after_b;
    logic                       slot_free;
    logic                       close;
    logic                       hit_all;
    logic signed [SCORE_W-1:0]  final_score;
    logic                       take_best;
    logic [CNT_W+10:0]          cnt_ext;
    logic [CNT_W+10:0]          best_ext;
    logic signed [10:0]         best_idx_out;

    assign eff_len   = (pattern_len > LEN_MAX) ? LEN_MAX : pattern_len;
    assign after_a   = score_step(cand_reg, q_data.op_a, pattern, eff_len);
    assign after_b   = score_step(after_a, q_data.op_b, pattern, eff_len);
    assign slot_free = !out_vld_reg || out_ready;
    assign q_pop     = q_valid && (!q_data.end_item || slot_free);
    assign close     = q_pop && q_data.end_item;

    always_comb
    begin
        if (eff_len == 5'd0)
            hit_all = !q_data.nonempty;
        else
            hit_all = after_b.pos >= eff_len;
        if (hit_all && (eff_len != 5'd0))
            final_score = sat13($signed({after_b.run[SCORE_W-1], after_b.run})
                                - $signed({10'b0, after_b.pen}));
        else
            final_score = '0;
        take_best = hit_all && (!best_vld_reg || (final_score > best_val_reg));
    end

    always_comb
    begin
        cand_next     = cand_reg;
        cnt_next      = cnt_reg;
        best_vld_next = best_vld_reg;
        best_cnt_next = best_cnt_reg;
        best_val_next = best_val_reg;
        if (q_pop)
            cand_next = after_b;
        if (close)
        begin
            cand_next = '0;
            cnt_next  = (cnt_reg == CNT_W'(MAX_ITEMS - 1)) ? '0 : cnt_reg + 1'b1;
            if (take_best)
            begin
                best_vld_next = 1'b1;
                best_cnt_next = cnt_reg;
                best_val_next = final_score;
            end
            if (q_data.end_list)
            begin
                cnt_next      = '0;
                best_vld_next = 1'b0;
                best_cnt_next = '0;
                best_val_next = '0;
            end
        end
    end

    // best values as seen by the result of the candidate being closed
    always_comb
    begin
        cnt_ext  = {11'b0, cnt_reg};
        best_ext = {11'b0, (take_best ? cnt_reg : best_cnt_reg)};
        if (take_best || best_vld_reg)
            best_idx_out = best_ext[10:0];
        else
            best_idx_out = '1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cand_reg     <= '0;
            cnt_reg      <= '0;
            best_vld_reg <= 1'b0;
            best_cnt_reg <= '0;
            best_val_reg <= '0;
            out_vld_reg  <= 1'b0;
        end
        else
        begin
            cand_reg     <= cand_next;
            cnt_reg      <= cnt_next;
            best_vld_reg <= best_vld_next;
            best_cnt_reg <= best_cnt_next;
            best_val_reg <= best_val_next;
            if (close)
                out_vld_reg <= 1'b1;
            else if (out_ready)
                out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (close)
        begin
            idx_reg   <= cnt_ext[9:0];
            match_reg <= hit_all;
            score_reg <= final_score;
            bidx_reg  <= best_idx_out;
            bval_reg  <= take_best ? final_score : best_val_reg;
            done_reg  <= q_data.end_list;
        end
    end

    assign out_valid  = out_vld_reg;
    assign item_index = idx_reg;
    assign matched    = match_reg;
    assign item_score = score_reg;
    assign best_index = bidx_reg;
    assign best_score = bval_reg;
    assign list_done  = done_reg;

endmodule

>>> src/fuzzy_match_best_item_unit.sv
// Fuzzy subsequence matcher: one character per beat in, one result beat per
// candidate, with a running best-match tracker. Sustains one input beat per clock
// while the result side keeps up: the back end scores up to two characters per
// queue entry in a single cycle, so a character stream never waits on scoring.
// A candidate's last beat waits in the two-entry queue and is scored into the
// result register once the result slot is free. While a result waits, the queue
// keeps taking beats until the entry that ends the next candidate reaches its head;
// the input stalls once both entries are full. The user must write the pattern
// registers only while no candidate is in flight; the block does not enforce this.
// Depends on fmb_pkg, fmb_front, fmb_queue and fmb_back.
`timescale 1ns / 1ps

module fuzzy_match_best_item_unit
    import fmb_pkg::*;
#(
    parameter int MAX_ITEMS = 1024
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [1:0]                 cfg_index,
    input  logic [63:0]                cfg_data,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [7:0]                 ch,
    input  logic                       has_char,
    input  logic                       end_of_item,
    input  logic                       end_of_list,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [9:0]                 item_index,
    output logic                       matched,
    output logic signed [SCORE_W-1:0]  item_score,
    output logic signed [10:0]         best_index,
    output logic signed [SCORE_W-1:0]  best_score,
    output logic                       list_done
);

    logic [63:0] pat_lo_reg;
    logic [63:0] pat_hi_reg;
    logic [4:0]  pat_len_reg;
    logic        cfg_we;

    logic        q_push;
    work_t       q_in;
    logic        q_not_full;
    logic        q_pop;
    logic        q_not_empty;
    work_t       q_out;

    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pat_lo_reg  <= '0;
            pat_hi_reg  <= '0;
            pat_len_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (reg_idx_t'(cfg_index))
                REG_PATTERN_LO:  pat_lo_reg  <= cfg_data;
                REG_PATTERN_HI:  pat_hi_reg  <= cfg_data;
                REG_PATTERN_LEN: pat_len_reg <= cfg_data[4:0];
                default:         ;
            endcase
        end
    end

    fmb_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .ch          (ch),
        .has_char    (has_char),
        .end_of_item (end_of_item),
        .end_of_list (end_of_list),
        .q_ready     (q_not_full),
        .q_push      (q_push),
        .q_data      (q_in)
    );

    fmb_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .not_full  (q_not_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .pop_data  (q_out)
    );

    fmb_back #(
        .MAX_ITEMS (MAX_ITEMS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .pattern     ({pat_hi_reg, pat_lo_reg}),
        .pattern_len (pat_len_reg),
        .q_valid     (q_not_empty),
        .q_data      (q_out),
        .q_pop       (q_pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .item_index  (item_index),
        .matched     (matched),
        .item_score  (item_score),
        .best_index  (best_index),
        .best_score  (best_score),
        .list_done   (list_done)
    );

    // a matched candidate always leaves a best entry behind it
    a_best_after_match: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && matched |-> best_index != 11'h7FF)
        else $error("best index empty on a matched result");

    // the best score can never trail the score of a matched candidate
    a_best_not_below: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && matched |-> $signed(item_score) <= $signed(best_score))
        else $error("best score below a matched item score");

    // unmatched candidates carry a zero score
    a_unmatched_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !matched |-> item_score == '0)
        else $error("nonzero score on an unmatched result");

    // a beat that closes a candidate must leave the queue only when the result slot is free
    a_close_slot: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop && q_out.end_item |-> !out_valid || out_ready)
        else $error("result register overwritten");

endmodule

>>> verif/fuzzy_match_best_item_unit_tb.sv
// fuzzy_match_best_item_unit_tb: self-checking bench for the fuzzy match unit, with
// random idling on both channels and a scoreboard that predicts every result beat
// depends on fmb_pkg and fuzzy_match_best_item_unit
`timescale 1ns / 1ps

module fuzzy_match_best_item_unit_tb
    import fmb_pkg::*;
();

    localparam int ITEM_SPAN    = 1024;
    localparam int PAT_SLOTS    = 16;
    localparam int HIT_PTS      = 10;
    localparam int RUN_PTS      = 5;
    localparam int LEAD_PEN     = 3;
    localparam int PEN_CAP      = 9;
    localparam int SAT_HI       = 4095;
    localparam int SAT_LO       = -4096;
    localparam int RANDOM_BEATS = 450;
    localparam int SETTLE       = 6;
    localparam int STALL_LIMIT  = 2000;

    typedef logic [7:0] text_t[$];

    typedef struct {
        logic [9:0]                index;
        logic                      hit;
        logic signed [SCORE_W-1:0] score;
        logic signed [10:0]        best_at;
        logic signed [SCORE_W-1:0] best;
        logic                      last;
    } outcome_t;

    class match_board;
        logic [63:0] pat_lo;
        logic [63:0] pat_hi;
        logic [4:0]  pat_len;
        int          pos;
        int          run;
        int          pen;
        int          count;
        int          best_i;
        int          best_v;
        logic [7:0]  held;
        logic [7:0]  prev;
        bit          held_ok;
        bit          consec;
        bit          nonempty;
        outcome_t    pending[$];
        int          errors;

        function void clear_item();
            pos      = 0;
            held     = 8'h00;
            held_ok  = 1'b0;
            prev     = 8'h00;
            consec   = 1'b0;
            run      = 0;
            pen      = 0;
            nonempty = 1'b0;
        endfunction

        function void clear_list();
            count  = 0;
            best_i = -1;
            best_v = 0;
        endfunction

        function void reset_all();
            pat_lo  = '0;
            pat_hi  = '0;
            pat_len = '0;
            errors  = 0;
            clear_item();
            clear_list();
        endfunction

        function void set_reg(reg_idx_t r, logic [63:0] d);
            case (r)
                REG_PATTERN_LO:  pat_lo = d;
                REG_PATTERN_HI:  pat_hi = d;
                REG_PATTERN_LEN: pat_len = d[4:0];
                default: ;
            endcase
        endfunction

        function int span();
            return (pat_len > PAT_SLOTS) ? PAT_SLOTS : int'(pat_len);
        endfunction

        function logic [7:0] pat_at(int k);
            return (k < 8) ? pat_lo[8*k +: 8] : pat_hi[8*(k-8) +: 8];
        endfunction

        function int clip(int v);
            if (v > SAT_HI)
                return SAT_HI;
            if (v < SAT_LO)
                return SAT_LO;
            return v;
        endfunction

        // score one held character, knowing the one after it
        function void score_one(logic [7:0] c, logic [7:0] nxt);
            logic [7:0] b;
            bit         lead;
            int         gain;
            b    = prev;
            prev = c;
            if (span() == 0 || pos >= span())
                return;
            lead = c[6] && !nxt[6];
            if (((c ^ pat_at(pos)) & 8'hDF) == 8'h00)
            begin
                gain   = (b <= 8'd32 || lead) ? HIT_PTS : (consec ? RUN_PTS : 0);
                consec = 1'b1;
                run    = clip(run + gain);
                pos++;
            end
            else
            begin
                consec = 1'b0;
                run    = clip(run - 1);
                if (lead)
                    pen = (pen + LEAD_PEN > PEN_CAP) ? PEN_CAP : pen + LEAD_PEN;
            end
        endfunction

        function void note_beat(logic [7:0] c, bit hc, bit eoi, bit eol);
            outcome_t o;
            bit       ok;
            int       sc;
            if (hc)
            begin
                nonempty = 1'b1;
                if (held_ok)
                    score_one(held, c);
                held    = c;
                held_ok = 1'b1;
            end
            if (!eoi)
                return;
            if (held_ok)
            begin
                score_one(held, 8'h00);
                held_ok = 1'b0;
            end
            sc = 0;
            if (span() == 0)
                ok = !nonempty;
            else
            begin
                ok = (pos >= span());
                if (ok)
                    sc = clip(run - pen);
            end
            if (ok && (best_i < 0 || sc > best_v))
            begin
                best_i = count;
                best_v = sc;
            end
            o.index   = count[9:0];
            o.hit     = ok;
            o.score   = sc[SCORE_W-1:0];
            o.best_at = best_i[10:0];
            o.best    = best_v[SCORE_W-1:0];
            o.last    = eol;
            pending.push_back(o);
            clear_item();
            count = (count + 1) % ITEM_SPAN;
            if (eol)
                clear_list();
        endfunction

        function void compare(string what, logic signed [31:0] want_v,
                              logic signed [31:0] got_v);
            if (got_v !== want_v)
            begin
                errors++;
                $display("%0t: %s expected %0d, got %0d", $time, what, want_v, got_v);
            end
        endfunction

        function void check_result(outcome_t got);
            outcome_t want;
            if (pending.size() == 0)
            begin
                errors++;
                $display("%0t: result for item %0d with nothing outstanding",
                         $time, got.index);
                return;
            end
            want = pending.pop_front();
            compare("item_index", want.index, got.index);
            compare("matched", want.hit, got.hit);
            compare("item_score", want.score, got.score);
            compare("best_index", want.best_at, got.best_at);
            compare("best_score", want.best, got.best);
            compare("list_done", want.last, got.last);
        endfunction
    endclass

    logic                      clk;
    logic                      rst_n;
    logic                      cfg_valid;
    logic                      cfg_ready;
    logic [1:0]                cfg_index;
    logic [63:0]               cfg_data;
    logic                      in_valid;
    logic                      in_ready;
    logic [7:0]                ch;
    logic                      has_char;
    logic                      end_of_item;
    logic                      end_of_list;
    logic                      out_valid;
    logic                      out_ready;
    logic [9:0]                item_index;
    logic                      matched;
    logic signed [SCORE_W-1:0] item_score;
    logic signed [10:0]        best_index;
    logic signed [SCORE_W-1:0] best_score;
    logic                      list_done;

    match_board board = new;
    logic [7:0] pat_bytes[PAT_SLOTS];
    int         pat_span;
    int         beats_sent;
    int         idle_cycles;
    bit         in_calm;
    bit         out_calm;

    fuzzy_match_best_item_unit #(.MAX_ITEMS(ITEM_SPAN)) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .ch          (ch),
        .has_char    (has_char),
        .end_of_item (end_of_item),
        .end_of_list (end_of_list),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .item_index  (item_index),
        .matched     (matched),
        .item_score  (item_score),
        .best_index  (best_index),
        .best_score  (best_score),
        .list_done   (list_done)
    );

    always #6 clk = ~clk;

    function automatic logic [7:0] pick_char();
        case ($urandom_range(0, 4))
            0: return 8'($urandom_range(0, 32));
            1: return 8'($urandom_range(65, 90));
            2: return 8'($urandom_range(97, 122));
            3: return 8'($urandom_range(48, 57));
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // first upto pattern bytes in order, random fill around them, case flipped at random
    function automatic text_t matching_text(int upto);
        text_t      s;
        logic [7:0] c;
        for (int k = 0; k < upto; k++)
        begin
            repeat ($urandom_range(0, 3)) s.push_back(pick_char());
            c = pat_bytes[k];
            if ($urandom_range(0, 1))
                c[5] = ~c[5];
            s.push_back(c);
        end
        repeat ($urandom_range(0, 3)) s.push_back(pick_char());
        return s;
    endfunction

    task automatic load_pattern(logic [63:0] lo, logic [63:0] hi, logic [4:0] len);
        logic [63:0] vals[3];
        reg_idx_t    ids[3];
        vals = '{lo, hi, {59'd0, len}};
        ids  = '{REG_PATTERN_LO, REG_PATTERN_HI, REG_PATTERN_LEN};
        for (int i = 0; i < 3; i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= ids[i];
            cfg_data  <= vals[i];
            do @(posedge clk); while (!cfg_ready);
            board.set_reg(ids[i], vals[i]);
        end
        cfg_valid <= 1'b0;
        for (int k = 0; k < PAT_SLOTS; k++)
            pat_bytes[k] = (k < 8) ? lo[8*k +: 8] : hi[8*(k-8) +: 8];
        pat_span = (len > PAT_SLOTS) ? PAT_SLOTS : int'(len);
    endtask

    // valid stays high across back-to-back beats; it only drops for a gap or in_stop
    task automatic push(logic [7:0] c, bit hc, bit eoi, bit eol);
        int gap;
        gap = in_calm ? 0 : $urandom_range(0, 9);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        ch          <= c;
        has_char    <= hc;
        end_of_item <= eoi;
        end_of_list <= eol;
        do @(posedge clk); while (!in_ready);
        board.note_beat(c, hc, eoi, eol);
        beats_sent++;
    endtask

    task automatic in_stop();
        in_valid <= 1'b0;
    endtask

    task automatic send_item(text_t s, bit eol);
        int n;
        bit tail_marker;
        bit is_end;
        n = s.size();
        tail_marker = (n == 0) || ($urandom_range(0, 5) == 0);
        for (int i = 0; i < n; i++)
        begin
            // ignored beats: marker with no char, list end without item end
            if ($urandom_range(0, 9) == 0)
                push(8'($urandom_range(0, 255)), 1'b0, 1'b0, 1'($urandom_range(0, 1)));
            is_end = !tail_marker && (i == n - 1);
            push(s[i], 1'b1, is_end, is_end ? eol : ($urandom_range(0, 3) == 0));
        end
        if (tail_marker)
            push(8'($urandom_range(0, 255)), 1'b0, 1'b1, eol);
    endtask

    // block must be idle before any register write
    task automatic settle();
        in_stop();
        while (board.pending.size() > 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    // result side: random stall per beat, then ready held until the beat is taken
    initial
    begin
        int       stall;
        outcome_t got;
        @(posedge rst_n);
        forever
        begin
            stall = out_calm ? 0 : $urandom_range(0, 9);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
            got.index   = item_index;
            got.hit     = matched;
            got.score   = item_score;
            got.best_at = best_index;
            got.best    = best_score;
            got.last    = list_done;
            board.check_result(got);
        end
    end

    initial
    begin
        text_t       s;
        logic [63:0] lo;
        logic [63:0] hi;
        logic [4:0]  len;
        int          phase;
        int          r;
        clk         = 1'b0;
        rst_n       = 1'b0;
        cfg_valid   = 1'b0;
        cfg_index   = REG_PATTERN_LO;
        cfg_data    = '0;
        in_valid    = 1'b0;
        ch          = '0;
        has_char    = 1'b0;
        end_of_item = 1'b0;
        end_of_list = 1'b0;
        out_ready   = 1'b0;
        idle_cycles = 0;
        beats_sent  = 0;
        in_calm     = 1'b0;
        out_calm    = 1'b0;
        pat_span    = 0;
        board.reset_all();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty query out of reset: only an empty candidate matches
        push(8'h00, 1'b0, 1'b1, 1'b0);
        push("a", 1'b1, 1'b1, 1'b0);
        settle();

        load_pattern(64'h6241, 64'h0, 5'd2);
        push("A", 1'b1, 1'b0, 1'b0);
        push("B", 1'b1, 1'b1, 1'b0);
        // leading miss, marker and stray list end in the middle
        push("x", 1'b1, 1'b0, 1'b0);
        push(8'hFF, 1'b0, 1'b0, 1'b1);
        push("a", 1'b1, 1'b0, 1'b0);
        push("b", 1'b1, 1'b1, 1'b0);
        push("a", 1'b1, 1'b0, 1'b0);
        push("9", 1'b1, 1'b0, 1'b0);
        push("b", 1'b1, 1'b1, 1'b0);
        push("Q", 1'b1, 1'b0, 1'b0);
        push(".", 1'b1, 1'b0, 1'b0);
        push("a", 1'b1, 1'b0, 1'b0);
        push("b", 1'b1, 1'b1, 1'b0);
        // chars after the pattern is consumed are ignored; list end resets best
        push("a", 1'b1, 1'b0, 1'b0);
        push("b", 1'b1, 1'b0, 1'b0);
        push("X", 1'b1, 1'b0, 1'b0);
        push("a", 1'b1, 1'b0, 1'b0);
        push("b", 1'b1, 1'b1, 1'b1);
        push(8'h00, 1'b0, 1'b1, 1'b1);
        settle();

        phase = 0;
        while (beats_sent < RANDOM_BEATS)
        begin
            for (int i = 0; i < 8; i++)
            begin
                lo[8*i +: 8] = pick_char();
                hi[8*i +: 8] = pick_char();
            end
            r = $urandom_range(0, 9);
            if (phase == 0)
            begin
                lo  = '1;
                hi  = '1;
                len = 5'd31;
            end
            else if (phase == 1)
            begin
                lo  = '0;
                hi  = '0;
                len = 5'd16;
            end
            else if (phase == 2 || r == 0)
                len = 5'd0;
            else if (r == 1)
                len = 5'd16;
            else if (r == 2)
                len = 5'($urandom_range(17, 31));
            else
                len = 5'($urandom_range(1, 5));
            load_pattern(lo, hi, len);
            in_calm  = ($urandom_range(0, 3) == 0);
            out_calm = ($urandom_range(0, 3) == 0);
            repeat ($urandom_range(6, 16))
            begin
                r = $urandom_range(0, 9);
                if (r < 6)
                    s = matching_text(pat_span);
                else if (r < 8)
                    s = matching_text($urandom_range(0, pat_span));
                else if (r == 8)
                begin
                    s.delete();
                    repeat ($urandom_range(1, 10)) s.push_back(pick_char());
                end
                else
                    s.delete();
                send_item(s, $urandom_range(0, 5) == 0);
            end
            settle();
            phase++;
        end

        if (board.errors == 0 && board.pending.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

>>> files.f
src/fmb_pkg.sv
src/fmb_front.sv
src/fmb_queue.sv
src/fmb_back.sv
src/fuzzy_match_best_item_unit.sv
verif/fuzzy_match_best_item_unit_tb.sv
